// ===== hdl/natp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// natp_pkg
// Shared types and constants of the nested activity time profiler.
// ----------------------------------------------------------------------------
package natp_pkg;

   localparam int OP_W   = 2;
   localparam int ACT_W  = 5;
   localparam int TS_W   = 48;
   localparam int CALL_W = 32;
   localparam int PCT_W  = 16;
   localparam int STAT_W = 2;

   localparam int REQ_W = 56;
   localparam int RSP_W = 104;

   localparam int NUM_W = 63;
   localparam int DSH_W = 64;

   localparam logic [OP_W-1:0] OP_BEGIN = 2'd0;
   localparam logic [OP_W-1:0] OP_END   = 2'd1;
   localparam logic [OP_W-1:0] OP_RESET = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_ACT  = 2'd3;

   localparam logic [PCT_W-1:0] PCT_MAX = 16'hFFFF;

endpackage

// ===== hdl/nested_activity_time_profiler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_activity_time_profiler_core
// Nested activity time profiler: per-activity tick totals and call counts
// held in memories, an activity stack in memory, and a query path with a
// serial divider for the share of the measuring period.
// ----------------------------------------------------------------------------
// One transaction at a time. Begin, end, reset totals and a query without a
// percentage have the result ready to be taken after a stack memory read, a
// totals memory read, then the read-modify-write. A query that computes a
// percentage adds a saturation check and, when the share does not saturate,
// the restoring divider that retires one quotient bit per cycle over 16 bits.
// A new request is taken the cycle after the previous result has been accepted.
module nested_activity_time_profiler_core #(
   parameter int NUM_ACTIVITIES = 32,
   parameter int STACK_DEPTH    = 128
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // op[1:0], activity[6:2], timestamp[54:7], zero pad
   input  logic [natp_pkg::REQ_W-1:0]   req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // total_ticks[47:0], call_count[79:48], percent_q8[95:80], status[97:96], zero pad
   output logic [natp_pkg::RSP_W-1:0]   rsp_tdata
);
   import natp_pkg::*;

   localparam int AW = $clog2(NUM_ACTIVITIES);
   localparam int SW = $clog2(STACK_DEPTH);
   localparam int CW = SW + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD1,
      S_RD2,
      S_SAT,
      S_DIV
   } state_type;

   state_type            state_ff;
   logic                 rsp_tvalid_ff;
   logic [RSP_W-1:0]     rsp_data_ff;

   logic [OP_W-1:0]      op_ff;
   logic [ACT_W-1:0]     act_ff;
   logic [TS_W-1:0]      ts_ff;

   logic [CW-1:0]        cnt_ff;
   logic [TS_W-1:0]      last_ff;
   logic [TS_W-1:0]      start_ff;
   logic [TS_W-1:0]      elapsed_ff;
   logic                 pvalid_ff;
   logic [NUM_ACTIVITIES-1:0] row_valid_ff;

   logic [ACT_W-1:0]     stack_mem [STACK_DEPTH];
   logic [TS_W-1:0]      ticks_mem [NUM_ACTIVITIES];
   logic [CALL_W-1:0]    calls_mem [NUM_ACTIVITIES];
   logic [ACT_W-1:0]     stack_q_ff;
   logic [TS_W-1:0]      tick_q_ff;
   logic [CALL_W-1:0]    call_q_ff;
   logic                 row_ok_ff;
   logic [AW-1:0]        idx_ff;

   logic [TS_W-1:0]      ticks_out_ff;
   logic [CALL_W-1:0]    calls_out_ff;
   logic [NUM_W-1:0]     num_ff;
   logic [DSH_W-1:0]     dsh_ff;
   logic [PCT_W-1:0]     quo_ff;
   logic [3:0]           bit_ff;

   logic                 accept;
   logic                 act_ok;
   logic [ACT_W-1:0]     top_act;
   logic [AW-1:0]        rd_idx_in;
   logic [TS_W-1:0]      tick_eff;
   logic [CALL_W-1:0]    call_eff;
   logic [TS_W-1:0]      delta;
   logic [TS_W:0]        tick_sum;
   logic [TS_W-1:0]      tick_in;
   logic [CALL_W-1:0]    call_in;
   logic [STAT_W-1:0]    status_in;
   logic                 charge;
   logic [TS_W-1:0]      elapsed_in;
   logic [NUM_W-1:0]     num_in;
   logic [NUM_W-1:0]     tick_wide;
   logic                 div_ge;
   logic [PCT_W-1:0]     quo_in;

   assign req_tready = (state_ff == S_IDLE) && !rsp_tvalid_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      act_ok    = int'(act_ff) < NUM_ACTIVITIES;
      top_act   = (cnt_ff == '0) ? '0 : stack_q_ff;
      if (op_ff == OP_BEGIN) begin
         rd_idx_in = AW'(top_act);
      end else if (act_ok) begin
         rd_idx_in = AW'(act_ff);
      end else begin
         rd_idx_in = '0;
      end
      tick_eff  = row_ok_ff ? tick_q_ff : '0;
      call_eff  = row_ok_ff ? call_q_ff : '0;
      delta     = ts_ff - last_ff;
      tick_sum  = {1'b0, tick_eff} + {1'b0, delta};
      tick_in   = tick_sum[TS_W] ? '1 : tick_sum[TS_W-1:0];
      call_in   = call_eff;
      if ((op_ff == OP_END) && (call_eff != '1)) begin
         call_in = call_eff + 1'b1;
      end
      case (op_ff)
         OP_BEGIN: begin
            if ((act_ff == '0) || !act_ok) begin
               status_in = ST_BAD_ACT;
            end else if (int'(cnt_ff) == STACK_DEPTH) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_OK;
            end
         end
         OP_END: begin
            if (!act_ok || (cnt_ff == '0) || (stack_q_ff != act_ff)) begin
               status_in = ST_MISMATCH;
            end else begin
               status_in = ST_OK;
            end
         end
         default: status_in = ST_OK;
      endcase
      charge     = (state_ff == S_RD2) && (status_in == ST_OK) &&
                   ((op_ff == OP_BEGIN) || (op_ff == OP_END));
      elapsed_in = (pvalid_ff && (elapsed_ff == '0)) ? (ts_ff - start_ff) : elapsed_ff;
      tick_wide  = NUM_W'(tick_eff);
      num_in     = (tick_wide << 14) + (tick_wide << 13) + (tick_wide << 10);
      div_ge     = DSH_W'(num_ff) >= dsh_ff;
      quo_in     = {quo_ff[PCT_W-2:0], div_ge};
   end

   // stack memory
   always_ff @(posedge clock) begin
      if (accept) begin
         stack_q_ff <= stack_mem[SW'(CW'(cnt_ff - 1'b1))];
      end
      if (charge && (op_ff == OP_BEGIN)) begin
         stack_mem[cnt_ff[SW-1:0]] <= act_ff;
      end
   end

   // totals memories
   always_ff @(posedge clock) begin
      if (state_ff == S_RD1) begin
         tick_q_ff <= ticks_mem[rd_idx_in];
         call_q_ff <= calls_mem[rd_idx_in];
         row_ok_ff <= row_valid_ff[rd_idx_in];
         idx_ff    <= rd_idx_in;
      end
      if (charge) begin
         ticks_mem[idx_ff] <= tick_in;
         calls_mem[idx_ff] <= call_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
         cnt_ff        <= '0;
         last_ff       <= '0;
         start_ff      <= '0;
         elapsed_ff    <= '0;
         pvalid_ff     <= 1'b0;
         row_valid_ff  <= '0;
      end else begin
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  op_ff    <= req_tdata[1:0];
                  act_ff   <= req_tdata[6:2];
                  ts_ff    <= req_tdata[54:7];
                  state_ff <= S_RD1;
               end
            end
            S_RD1: begin
               state_ff <= S_RD2;
            end
            S_RD2: begin
               if (charge) begin
                  last_ff              <= ts_ff;
                  row_valid_ff[idx_ff] <= 1'b1;
                  if (op_ff == OP_BEGIN) begin
                     cnt_ff <= cnt_ff + 1'b1;
                  end else begin
                     cnt_ff <= cnt_ff - 1'b1;
                  end
               end
               if (op_ff == OP_RESET) begin
                  row_valid_ff <= '0;
                  start_ff     <= ts_ff;
                  elapsed_ff   <= '0;
                  pvalid_ff    <= 1'b1;
               end
               if (op_ff == OP_QUERY) begin
                  elapsed_ff   <= elapsed_in;
                  ticks_out_ff <= act_ok ? tick_eff : '0;
                  calls_out_ff <= act_ok ? call_eff : '0;
                  if (act_ok && (elapsed_in != '0)) begin
                     num_ff   <= num_in;
                     dsh_ff   <= {1'b0, elapsed_in, 15'b0};
                     state_ff <= S_SAT;
                  end else begin
                     rsp_data_ff   <= {6'b0, ST_OK, {PCT_W{1'b0}},
                                       act_ok ? call_eff : {CALL_W{1'b0}},
                                       act_ok ? tick_eff : {TS_W{1'b0}}};
                     rsp_tvalid_ff <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               end else begin
                  rsp_data_ff   <= {6'b0, status_in, {PCT_W{1'b0}},
                                    {CALL_W{1'b0}}, {TS_W{1'b0}}};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            S_SAT: begin
               if (DSH_W'(num_ff) >= {dsh_ff[DSH_W-2:0], 1'b0}) begin
                  rsp_data_ff   <= {6'b0, ST_OK, PCT_MAX, calls_out_ff, ticks_out_ff};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  quo_ff   <= '0;
                  bit_ff   <= 4'd15;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_ge) begin
                  num_ff <= num_ff - dsh_ff[NUM_W-1:0];
               end
               dsh_ff <= dsh_ff >> 1;
               quo_ff <= quo_in;
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == 4'd0) begin
                  rsp_data_ff   <= {6'b0, ST_OK, quo_in, calls_out_ff, ticks_out_ff};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== verif/nested_activity_time_profiler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nested_activity_time_profiler_core_tb
// Self-checking bench for the nested activity time profiler. A directed
// table covers reset values, error codes, timestamp wrap and the period
// latch; a stack overflow, random begin/end nests, resets and queries follow.
// Every result is checked field by field against an in-bench profiler model.
// ----------------------------------------------------------------------------
module nested_activity_time_profiler_core_tb;
   import natp_pkg::*;

   localparam int NACT   = 32;
   localparam int SDEPTH = 128;
   localparam int N_RAND = 770;
   localparam longint LIMIT = 400000;
   localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
   localparam logic [CALL_W-1:0] CALL_MAX = {CALL_W{1'b1}};

   typedef struct packed {
      logic [TS_W-1:0]   ticks;
      logic [CALL_W-1:0] calls;
      logic [PCT_W-1:0]  pct;
      logic [STAT_W-1:0] status;
   } prof_rsp_type;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [ACT_W-1:0] act;
      logic [TS_W-1:0]  ts;
      bit               has_exp;
      logic [STAT_W-1:0] st;
      logic [TS_W-1:0]  ticks;
      logic [CALL_W-1:0] calls;
      logic [PCT_W-1:0] pct;
   } dir_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;

   nested_activity_time_profiler_core dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // profiler state
   logic [ACT_W-1:0]  pf_stack [SDEPTH];
   int                pf_depth;
   logic [TS_W-1:0]   pf_last;
   logic [TS_W-1:0]   pf_ticks [NACT];
   logic [CALL_W-1:0] pf_calls [NACT];
   logic [TS_W-1:0]   pf_pstart;
   logic [TS_W-1:0]   pf_elapsed;
   bit                pf_open;

   prof_rsp_type expected_q [$];
   int  mismatches = 0;
   int  n_rsp = 0;
   int  n_err = 0;
   int  n_query = 0;
   int  max_depth = 0;
   longint cycles = 0;
   bit  stall_free = 0;
   logic [TS_W-1:0] now_ts = '0;

   function automatic void clear_profile();
      pf_depth = 0;
      pf_last = '0;
      for (int i = 0; i < NACT; i++) begin
         pf_ticks[i] = '0;
         pf_calls[i] = '0;
      end
      pf_pstart = '0;
      pf_elapsed = '0;
      pf_open = 0;
   endfunction

   function automatic void charge_ticks(int idx, logic [TS_W-1:0] now);
      logic [TS_W:0] sum;
      sum = {1'b0, pf_ticks[idx]} + {1'b0, now - pf_last};
      pf_ticks[idx] = sum[TS_W] ? TS_MAX : sum[TS_W-1:0];
      pf_last = now;
   endfunction

   function automatic prof_rsp_type profile_event(logic [OP_W-1:0] op,
                                                  logic [ACT_W-1:0] act,
                                                  logic [TS_W-1:0] now);
      prof_rsp_type r;
      logic [TS_W+15:0] prod;
      logic [TS_W+15:0] q;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_BEGIN: begin
            if (act == 0) r.status = ST_BAD_ACT;
            else if (pf_depth >= SDEPTH) r.status = ST_FULL;
            else begin
               charge_ticks(pf_depth > 0 ? int'(pf_stack[pf_depth-1]) : 0, now);
               pf_stack[pf_depth] = act;
               pf_depth++;
               if (pf_depth > max_depth) max_depth = pf_depth;
            end
         end
         OP_END: begin
            if (pf_depth == 0 || pf_stack[pf_depth-1] != act) r.status = ST_MISMATCH;
            else begin
               pf_depth--;
               charge_ticks(act, now);
               if (pf_calls[act] != CALL_MAX) pf_calls[act]++;
            end
         end
         OP_RESET: begin
            for (int i = 0; i < NACT; i++) begin
               pf_ticks[i] = '0;
               pf_calls[i] = '0;
            end
            pf_pstart = now;
            pf_elapsed = '0;
            pf_open = 1;
         end
         default: begin
            if (pf_open && pf_elapsed == 0) pf_elapsed = now - pf_pstart;
            r.ticks = pf_ticks[act];
            r.calls = pf_calls[act];
            if (pf_elapsed != 0) begin
               prod = {16'd0, r.ticks} * (TS_W+16)'(25600);
               q = prod / {16'd0, pf_elapsed};
               r.pct = (q > (TS_W+16)'(PCT_MAX)) ? PCT_MAX : q[PCT_W-1:0];
            end
         end
      endcase
      return r;
   endfunction

   task automatic send_event(logic [OP_W-1:0] op, logic [ACT_W-1:0] act,
                             logic [TS_W-1:0] ts);
      prof_rsp_type r;
      @(posedge clock);
      while (!stall_free && $urandom_range(99) < 29) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {1'b0, ts, act, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 0;
      r = profile_event(op, act, ts);
      if (r.status != ST_OK) n_err++;
      if (op == OP_QUERY) n_query++;
      expected_q.push_back(r);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [TS_W-1:0] step_ts();
      case ($urandom_range(9))
         0: now_ts = now_ts + TS_W'({$urandom(), $urandom()});
         1: now_ts = now_ts;
         default: now_ts = now_ts + $urandom_range(1, 5000);
      endcase
      return now_ts;
   endfunction

   always @(posedge clock) begin
      prof_rsp_type got, exp;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[47:0], rsp_tdata[79:48], rsp_tdata[95:80], rsp_tdata[97:96]};
         n_rsp++;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            exp = expected_q.pop_front();
            if (got !== exp) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch #%0d: exp ticks=%h calls=%h pct=%h st=%0d, ",
                            "got ticks=%h calls=%h pct=%h st=%0d"},
                           n_rsp, exp.ticks, exp.calls, exp.pct, exp.status,
                           got.ticks, got.calls, got.pct, got.status);
            end
         end
      end
      rsp_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= 29);
   end

   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   dir_row_type dir_tab [$];

   function automatic void add_row(logic [OP_W-1:0] op, logic [ACT_W-1:0] act,
                                   logic [TS_W-1:0] ts, bit has_exp = 0,
                                   logic [STAT_W-1:0] st = ST_OK,
                                   logic [TS_W-1:0] ticks = '0,
                                   logic [CALL_W-1:0] calls = '0,
                                   logic [PCT_W-1:0] pct = '0);
      dir_row_type d;
      d.op = op; d.act = act; d.ts = ts; d.has_exp = has_exp;
      d.st = st; d.ticks = ticks; d.calls = calls; d.pct = pct;
      dir_tab.push_back(d);
   endfunction

   initial begin
      int kind;
      int a;
      prof_rsp_type tr;
      clear_profile();
      // reset state, error codes, wrap and latch
      add_row(OP_QUERY, 5'd31, TS_MAX, 1, ST_OK);
      add_row(OP_END, 5'd3, 48'd10, 1, ST_MISMATCH);
      add_row(OP_BEGIN, 5'd0, 48'd10, 1, ST_BAD_ACT);
      add_row(OP_BEGIN, 5'd31, 48'd100);
      add_row(OP_BEGIN, 5'd1, 48'd150);
      add_row(OP_END, 5'd31, 48'd160, 1, ST_MISMATCH);
      add_row(OP_END, 5'd1, 48'd400);
      add_row(OP_END, 5'd31, TS_MAX - 48'd5);
      add_row(OP_QUERY, 5'd0, 48'd0);
      add_row(OP_RESET, 5'd0, TS_MAX - 48'd100);
      add_row(OP_QUERY, 5'd0, TS_MAX - 48'd100, 1, ST_OK);
      add_row(OP_BEGIN, 5'd7, 48'd50);
      add_row(OP_BEGIN, 5'd21, 48'd60);
      add_row(OP_END, 5'd21, 48'd90);
      add_row(OP_END, 5'd7, 48'd200);
      add_row(OP_QUERY, 5'd7, 48'd300);
      add_row(OP_QUERY, 5'd0, 48'd300);
      add_row(OP_QUERY, 5'd21, TS_MAX);
      add_row(OP_BEGIN, 5'd10, 48'h0F0F_0F0F_0F0F);
      add_row(OP_END, 5'd10, 48'hF0F0_F0F0_F0F0);
      add_row(OP_RESET, 5'd31, 48'h5555_5555_5555);
      add_row(OP_QUERY, 5'd10, 48'h5555_5555_5555, 1, ST_OK);
      add_row(OP_QUERY, 5'd10, 48'hAAAA_AAAA_AAAA, 1, ST_OK);

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (dir_tab[i]) begin
         send_event(dir_tab[i].op, dir_tab[i].act, dir_tab[i].ts);
         if (dir_tab[i].has_exp) begin
            tr = {dir_tab[i].ticks, dir_tab[i].calls, dir_tab[i].pct, dir_tab[i].st};
            if (expected_q[$] !== tr) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("table row %0d: model %h, table %h", i, expected_q[$], tr);
            end
         end
      end
      wait_drained();
      now_ts = pf_last;

      // fill the stack to overflow, then unwind
      stall_free = 1;
      for (int i = 0; i < SDEPTH + 2; i++)
         send_event(OP_BEGIN, 5'($urandom_range(1, 31)), step_ts());
      while (pf_depth > 0) send_event(OP_END, pf_stack[pf_depth-1], step_ts());
      stall_free = 0;

      for (int n = 0; n < N_RAND; n++) begin
         if (n >= 400 && n < 550) stall_free = 1;
         else stall_free = 0;
         if (n == 700) wait_drained();
         kind = $urandom_range(99);
         if (kind < 40 && pf_depth < SDEPTH)
            send_event(OP_BEGIN, 5'($urandom_range(1, 31)), step_ts());
         else if (kind < 75 && pf_depth > 0)
            send_event(OP_END, pf_stack[pf_depth-1], step_ts());
         else if (kind < 80)
            send_event(OP_RESET, 5'($urandom), step_ts());
         else if (kind < 93) begin
            a = (pf_depth > 0 && $urandom_range(1)) ? int'(pf_stack[pf_depth-1]) :
                $urandom_range(31);
            send_event(OP_QUERY, 5'(a), step_ts());
         end else
            send_event(2'($urandom_range(1)), 5'($urandom),
                       TS_W'({$urandom(), $urandom()}));
         if ($urandom_range(199) == 0) now_ts = pf_last;
      end

      stall_free = 0;
      wait_drained();
      repeat (40) @(posedge clock);
      $display("Checked %0d responses: %0d queries, %0d error events, stack depth up to %0d.",
               n_rsp, n_query, n_err, max_depth);
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d responses outstanding", mismatches, expected_q.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
